FILE: hdl/murmur_hash_64a_defines.svh
// Assertion macros shared by the checker files of the MurmurHash64A block.
// Depends on nothing; the including module must declare clk_i and rst_ni.
`ifndef MURMUR_HASH_64A_DEFINES_SVH
`define MURMUR_HASH_64A_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MH64_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mh64 check failed");

// Consequent checked in the cycle after the antecedent.
`define MH64_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mh64 check failed");

`endif

FILE: hdl/mh64_pkg.sv
// Shared types and constants of the MurmurHash64A block: micro-op format,
// hash constants and the tail byte mask. Depends on nothing.
`timescale 1ns / 1ps

package mh64_pkg;

  localparam logic [63:0] MUR_M   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MUR_R   = 47;
  localparam int unsigned UPC_W   = 5;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_op_e;

  typedef enum logic [1:0] {
    SRC_LEN,
    SRC_K,
    SRC_H
  } mul_src_e;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_H_INIT,
    ALU_K_XSH,
    ALU_H_XORP,
    ALU_H_XORT,
    ALU_H_GETP,
    ALU_H_XSH
  } alu_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_IF_NOT_FIRST,
    J_IF_CNT_ZERO,
    J_IF_PARTIAL,
    J_IF_NOT_LAST
  } jmp_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    mul_op_e            mul;
    mul_src_e           src;
    alu_op_e            alu;
    jmp_e               jmp;
    logic [UPC_W-1:0]   target;
    logic               emit;
    logic               done;
  } mh64_uop_t;

  localparam mh64_uop_t UOP_NOP = '{
    mul:    MUL_NONE,
    src:    SRC_K,
    alu:    ALU_NONE,
    jmp:    J_NEXT,
    target: '0,
    emit:   1'b0,
    done:   1'b0
  };

  // Byte mask for a tail word of cnt valid bytes (cnt below eight).
  function automatic logic [63:0] tail_mask(input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hdl/mh64_ucode.sv
// Microcode store of the MurmurHash64A sequencer: one control word per step.
// Depends on mh64_pkg.
`timescale 1ns / 1ps

module mh64_ucode import mh64_pkg::*; (
  input  logic [UPC_W-1:0] upc_i,
  output mh64_uop_t        uop_o
);

  localparam logic [UPC_W-1:0] UPC_ABSORB = UPC_W'(5);
  localparam logic [UPC_W-1:0] UPC_TAIL   = UPC_W'(15);
  localparam logic [UPC_W-1:0] UPC_HMUL   = UPC_W'(16);
  localparam logic [UPC_W-1:0] UPC_CHECK  = UPC_W'(20);
  localparam logic [UPC_W-1:0] UPC_EXIT   = UPC_W'(27);

  always_comb begin
    uop_o = UOP_NOP;
    case (upc_i)
      // start of message: h = seed ^ (len * M)
      5'd0: begin
        uop_o.jmp    = J_IF_NOT_FIRST;
        uop_o.target = UPC_ABSORB;
      end
      5'd1: begin uop_o.mul = MUL_LL; uop_o.src = SRC_LEN; end
      5'd2: begin uop_o.mul = MUL_HL; uop_o.src = SRC_LEN; end
      5'd3: begin uop_o.mul = MUL_LH; uop_o.src = SRC_LEN; end
      5'd4: uop_o.alu = ALU_H_INIT;
      // dispatch on byte count
      5'd5: begin
        uop_o.jmp    = J_IF_CNT_ZERO;
        uop_o.target = UPC_CHECK;
      end
      5'd6: begin
        uop_o.jmp    = J_IF_PARTIAL;
        uop_o.target = UPC_TAIL;
      end
      // full word mix: k *= M; k ^= k >> R; k *= M; h ^= k
      5'd7:  begin uop_o.mul = MUL_LL; uop_o.src = SRC_K; end
      5'd8:  begin uop_o.mul = MUL_HL; uop_o.src = SRC_K; end
      5'd9:  begin uop_o.mul = MUL_LH; uop_o.src = SRC_K; end
      5'd10: uop_o.alu = ALU_K_XSH;
      5'd11: begin uop_o.mul = MUL_LL; uop_o.src = SRC_K; end
      5'd12: begin uop_o.mul = MUL_HL; uop_o.src = SRC_K; end
      5'd13: begin uop_o.mul = MUL_LH; uop_o.src = SRC_K; end
      5'd14: begin
        uop_o.alu    = ALU_H_XORP;
        uop_o.jmp    = J_ALWAYS;
        uop_o.target = UPC_HMUL;
      end
      5'd15: uop_o.alu = ALU_H_XORT;
      // h *= M
      5'd16: begin uop_o.mul = MUL_LL; uop_o.src = SRC_H; end
      5'd17: begin uop_o.mul = MUL_HL; uop_o.src = SRC_H; end
      5'd18: begin uop_o.mul = MUL_LH; uop_o.src = SRC_H; end
      5'd19: uop_o.alu = ALU_H_GETP;
      5'd20: begin
        uop_o.jmp    = J_IF_NOT_LAST;
        uop_o.target = UPC_EXIT;
      end
      // finalization
      5'd21: uop_o.alu = ALU_H_XSH;
      5'd22: begin uop_o.mul = MUL_LL; uop_o.src = SRC_H; end
      5'd23: begin uop_o.mul = MUL_HL; uop_o.src = SRC_H; end
      5'd24: begin uop_o.mul = MUL_LH; uop_o.src = SRC_H; end
      5'd25: uop_o.alu = ALU_H_GETP;
      5'd26: begin
        uop_o.alu  = ALU_H_XSH;
        uop_o.emit = 1'b1;
        uop_o.done = 1'b1;
      end
      5'd27: uop_o.done = 1'b1;
      default: uop_o.done = 1'b1;
    endcase
  end

endmodule

FILE: hdl/mh64_dp.sv
// Datapath of the MurmurHash64A block: word registers, running hash and a
// shared 32x32 multiplier that builds products by M in three passes.
// Depends on mh64_pkg.
`timescale 1ns / 1ps

module mh64_dp import mh64_pkg::*; (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic [30:0] message_length_i,
  input  logic [63:0] seed_i,
  input  mh64_uop_t   uop_i,
  output logic [63:0] hash_fin_o
);

  logic [63:0] k_q, k_d;
  logic [63:0] h_q, h_d;
  logic [63:0] p_q, p_d;
  logic [63:0] seed_q;
  logic [30:0] len_q;
  logic [63:0] tail_q;

  logic [63:0] x;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  always_comb begin
    case (uop_i.src)
      SRC_LEN: x = {33'b0, len_q};
      SRC_K:   x = k_q;
      SRC_H:   x = h_q;
      default: x = k_q;
    endcase
  end

  // x * M mod 2^64 = xl*ml + ((xh*ml + xl*mh) << 32)
  assign mul_a = (uop_i.mul == MUL_HL) ? x[63:32] : x[31:0];
  assign mul_b = (uop_i.mul == MUL_LH) ? MUR_M[63:32] : MUR_M[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    case (uop_i.mul)
      MUL_LL:  p_d = prod;
      MUL_HL:  p_d = p_q + {prod[31:0], 32'b0};
      MUL_LH:  p_d = p_q + {prod[31:0], 32'b0};
      default: p_d = p_q;
    endcase
  end

  always_comb begin
    k_d = k_q;
    h_d = h_q;
    case (uop_i.alu)
      ALU_H_INIT: h_d = seed_q ^ p_q;
      ALU_K_XSH:  k_d = p_q ^ (p_q >> MUR_R);
      ALU_H_XORP: h_d = h_q ^ p_q;
      ALU_H_XORT: h_d = h_q ^ tail_q;
      ALU_H_GETP: h_d = p_q;
      ALU_H_XSH:  h_d = h_q ^ (h_q >> MUR_R);
      default: begin
        k_d = k_q;
        h_d = h_q;
      end
    endcase
    if (load_i) begin
      k_d = data_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    h_q <= h_d;
    p_q <= p_d;
    if (load_i) begin
      seed_q <= seed_i;
      len_q  <= message_length_i;
      tail_q <= data_word_i & tail_mask(byte_count_i);
    end
  end

  assign hash_fin_o = h_q ^ (h_q >> MUR_R);

endmodule

FILE: hdl/murmur_hash_64a.sv
// MurmurHash64A block: microcoded sequencer, handshake and result register.
// Depends on mh64_pkg, mh64_ucode and mh64_dp.
//
// Usage: a message streams in as little-endian 64-bit words on the input
// channel (in_valid_i / in_stall_o). The first word of a message also brings
// seed_i and message_length_i; every word brings byte_count_i (8 for full
// words, 1 to 7 for a tail, 0 only for an empty message) and last_word_i.
// The word marked last produces one result on the output channel
// (out_valid_o / out_stall_i, hash_value_o); other words produce none.
// One word is worked at a time: in_stall_o stays high from the cycle after a
// word is accepted until its microprogram ends. A full word, a tail and a
// zero-byte word take different microprogram paths; the first word of a
// message adds the length steps and the last adds finalization. The time is
// set by the single 32x32 multiplier, which forms each 64-bit product by M in
// three passes, and by the microprogram, one step per cycle while not held.
// Reset clears the sequencer to idle, marks the result register empty and puts
// the block in the awaiting-first-word state. When the receiver stalls a
// held result, the sequencer holds at the step that emits a new one.
`timescale 1ns / 1ps

module murmur_hash_64a import mh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  input  logic [30:0] message_length_i,
  input  logic [63:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  seq_state_e        state_q, state_d;
  logic [UPC_W-1:0]  upc_q, upc_d;
  logic              in_msg_q, in_msg_d;
  logic              out_vld_q, out_vld_d;
  logic [63:0]       hash_q;

  // flags of the word under work
  logic              cnt_zero_q, cnt_full_q, last_q;

  mh64_uop_t         uop, uop_exec;
  logic              accept;
  logic              run;
  logic              hold;
  logic              taken;
  logic              emit;
  logic [63:0]       hash_fin;

  mh64_ucode u_ucode (
    .upc_i (upc_q),
    .uop_o (uop)
  );

  mh64_dp u_dp (
    .clk_i            (clk_i),
    .load_i           (accept),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .message_length_i (message_length_i),
    .seed_i           (seed_i),
    .uop_i            (uop_exec),
    .hash_fin_o       (hash_fin)
  );

  assign in_stall_o = (state_q != SEQ_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign run        = (state_q == SEQ_RUN);
  // hold the emit step while an older result is still stalled
  assign hold       = uop.emit && out_vld_q && out_stall_i;
  assign emit       = run && !hold && uop.emit;

  always_comb begin
    case (uop.jmp)
      J_NEXT:         taken = 1'b0;
      J_ALWAYS:       taken = 1'b1;
      J_IF_NOT_FIRST: taken = in_msg_q;
      J_IF_CNT_ZERO:  taken = cnt_zero_q;
      J_IF_PARTIAL:   taken = !cnt_full_q;
      J_IF_NOT_LAST:  taken = !last_q;
      default:        taken = 1'b0;
    endcase
  end

  // sequencer next state; drop datapath ops while idle or held
  always_comb begin
    state_d  = state_q;
    upc_d    = upc_q;
    in_msg_d = in_msg_q;
    uop_exec = UOP_NOP;
    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          state_d = SEQ_RUN;
          upc_d   = '0;
        end
      end
      SEQ_RUN: begin
        if (!hold) begin
          uop_exec = uop;
          if (uop.done) begin
            state_d  = SEQ_IDLE;
            in_msg_d = !last_q;
          end else if (taken) begin
            upc_d = uop.target;
          end else begin
            upc_d = upc_q + UPC_W'(1);
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      upc_q     <= '0;
      in_msg_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      upc_q     <= upc_d;
      in_msg_q  <= in_msg_d;
      out_vld_q <= out_vld_d;
    end
  end

  // word flags and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_zero_q <= (byte_count_i == 4'd0);
      cnt_full_q <= byte_count_i[3];
      last_q     <= last_word_i;
    end
    if (emit) begin
      hash_q <= hash_fin;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hash_value_o = hash_q;

endmodule

FILE: hdl/mh64_chk.sv
// Port-level checker of the MurmurHash64A block, bound to the top level.
// Depends on murmur_hash_64a_defines.svh and murmur_hash_64a.
`timescale 1ns / 1ps
`include "murmur_hash_64a_defines.svh"

module mh64_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_value_o
);

  // a stalled result stays put
  `MH64_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(hash_value_o))

  // one word at a time: an accepted word closes the input side
  `MH64_ASSERT_NEXT(a_one_word, in_valid_i && !in_stall_o, in_stall_o)

  // the input side only closes because a word was taken
  `MH64_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(in_valid_i))

  // a new result only comes out of a running microprogram
  `MH64_ASSERT_NOW(a_out_source, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind murmur_hash_64a mh64_chk u_chk (.*);
